@@ src/adcbar_pkg.sv @@
// Package for the block-averaging ratiometric ADC front end.
// Holds transaction payload types, field widths, register indexes and sequencer states.
// No dependencies.
`default_nettype none

package adcbar_pkg;

   localparam int SAMPLE_W = 12;
   localparam int AVG_W    = 12;
   localparam int VOLT_W   = 16;
   localparam int RATIO_W  = 8;
   localparam int CNT_W    = 9;
   localparam int CNT_MAX  = (1 << CNT_W) - 1;
   localparam int NUM_CH   = 5;
   localparam int CH_W     = 3;
   localparam int MUL_W    = VOLT_W + AVG_W;
   localparam int PROD_W   = MUL_W + RATIO_W;
   localparam int STEP_W   = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [AVG_W-1:0]  AVG_MAX  = '1;
   localparam logic [VOLT_W-1:0] VOLT_MAX = '1;

   localparam logic [CH_W-1:0] CH_SUPPLY = 3'd0;
   localparam logic [CH_W-1:0] CH_REF    = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_AVERAGE_COUNT        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE_MILLIVOLTS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDER_RATIO        = 2'd2;

   localparam logic [CNT_W-1:0]   RESET_AVERAGE_COUNT = 9'd16;
   localparam logic [VOLT_W-1:0]  RESET_REFERENCE_MV  = 16'd2500;
   localparam logic [RATIO_W-1:0] RESET_DIVIDER_RATIO = 8'd1;

   typedef struct packed {
      logic [SAMPLE_W-1:0] supply_sample;
      logic [SAMPLE_W-1:0] thermistor1_sample;
      logic [SAMPLE_W-1:0] thermistor2_sample;
      logic [SAMPLE_W-1:0] current_sample;
      logic [SAMPLE_W-1:0] reference_sample;
   } req_type;

   typedef struct packed {
      logic [VOLT_W-1:0] supply_voltage;
      logic [AVG_W-1:0]  thermistor1_average;
      logic [AVG_W-1:0]  thermistor2_average;
      logic [AVG_W-1:0]  current_average;
      logic [AVG_W-1:0]  reference_average;
      logic              reference_zero;
      logic              voltage_saturated;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG,
      ST_MUL1,
      ST_MUL2,
      ST_VDIV,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

@@ src/adcbar_if.sv @@
// Channel interfaces for the block-averaging ratiometric ADC front end.
// Sample, result and register write channels; each uses types or widths from adcbar_pkg.
`default_nettype none

interface adcbar_req_if;
   logic              valid;
   logic              ready;
   adcbar_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface adcbar_rsp_if;
   logic              valid;
   logic              ready;
   adcbar_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface adcbar_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [adcbar_pkg::CSR_IDX_W-1:0]  index;
   logic [adcbar_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/adc_block_average_ratiometric_top.sv @@
// Block-averaging front end for five ADC channels with ratiometric supply scaling.
// Depends on adcbar_pkg and the channel interfaces in adcbar_if.sv.
//
// Usage: each req transaction carries one sample of each of the five channels.
// The first N transactions of a block are summed and give no
// result. The next transaction closes the block: its samples are ignored, the
// five sums are divided by N, and one rsp transaction carries four averages and
// the supply voltage reference_millivolts * avg_supply * divider_ratio / avg_ref.
// While a closing transaction is processed, the single radix-2 restoring divider
// runs the five average divisions and the voltage division one after another.
// When the reference average is zero the voltage division is skipped. req ready
// is low during that time. Registers are written through the csr channel, which
// is always ready. The user must write them only while the block is idle; the
// block does not enforce it. The result waits in an output register; while
// the receiver stalls, further summing transactions are still accepted, and the
// next closing transaction holds before its result until the register is free.
// Reset is synchronous: sums and sample counter clear and registers return to
// average_count 16, reference_millivolts 2500, divider_ratio 1.
`default_nettype none

module adc_block_average_ratiometric_top #(
   parameter int SAMPLE_BITS = 12,
   parameter int MAX_AVERAGE = 256
) (
   input  logic         clock,
   input  logic         reset,
   adcbar_req_if.sink   req_chan,
   adcbar_rsp_if.source rsp_chan,
   adcbar_csr_if.sink   csr_chan
);

   import adcbar_pkg::*;

   localparam int IN_W  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int SUM_W = IN_W + $clog2(MAX_AVERAGE + 1);
   localparam logic [CNT_W-1:0] MAX_N =
      CNT_W'((MAX_AVERAGE > CNT_MAX) ? CNT_MAX : MAX_AVERAGE);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]   avg_count_ff;
   logic [VOLT_W-1:0]  ref_mv_ff;
   logic [RATIO_W-1:0] ratio_ff;

   logic [CNT_W-1:0] cnt_ff;
   logic [SUM_W-1:0] sums_ff [NUM_CH];
   logic [AVG_W-1:0] avg_ff  [NUM_CH];
   logic [CH_W-1:0]  chan_ff;

   logic [PROD_W-1:0] dvd_ff;
   logic [AVG_W-1:0]  rem_ff;
   logic [AVG_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] step_ff;
   logic [MUL_W-1:0]  prod_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic [CNT_W-1:0]  eff_n;
   logic              accum;
   logic              req_fire;
   logic              slot_free;
   logic [AVG_W:0]    rem_shift;
   logic              take;
   logic [AVG_W-1:0]  rem_next;
   logic [PROD_W-1:0] dvd_next;
   logic [AVG_W-1:0]  quot_avg;
   logic [CH_W-1:0]   chan_next;
   logic [SUM_W-1:0]  samples [NUM_CH];

   assign samples[0] = SUM_W'(req_chan.data.supply_sample[IN_W-1:0]);
   assign samples[1] = SUM_W'(req_chan.data.thermistor1_sample[IN_W-1:0]);
   assign samples[2] = SUM_W'(req_chan.data.thermistor2_sample[IN_W-1:0]);
   assign samples[3] = SUM_W'(req_chan.data.current_sample[IN_W-1:0]);
   assign samples[4] = SUM_W'(req_chan.data.reference_sample[IN_W-1:0]);

   always_comb begin
      if (avg_count_ff == '0) begin
         eff_n = CNT_W'(1);
      end else if (32'(avg_count_ff) > 32'(MAX_AVERAGE)) begin
         eff_n = MAX_N;
      end else begin
         eff_n = avg_count_ff;
      end
   end

   assign accum     = (cnt_ff < eff_n);
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign chan_next = chan_ff + CH_W'(1);

   // One restoring division step; quotient bits shift into the dividend register.
   assign rem_shift = {rem_ff, dvd_ff[PROD_W-1]};
   assign take      = (rem_shift >= {1'b0, dvs_ff});
   assign rem_next  = take ? AVG_W'(rem_shift - {1'b0, dvs_ff}) : rem_shift[AVG_W-1:0];
   assign dvd_next  = {dvd_ff[PROD_W-2:0], take};
   assign quot_avg  = (dvd_ff > PROD_W'(AVG_MAX)) ? AVG_MAX : dvd_ff[AVG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_chan.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_fire && !accum) begin
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            if (step_ff == '0 && chan_ff == CH_REF) begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            state_in = (avg_ff[CH_REF] == '0) ? ST_DONE : ST_VDIV;
         end
         ST_VDIV: begin
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_count_ff <= RESET_AVERAGE_COUNT;
         ref_mv_ff    <= RESET_REFERENCE_MV;
         ratio_ff     <= RESET_DIVIDER_RATIO;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CH; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         if (csr_chan.valid) begin
            case (csr_chan.index)
               CSR_AVERAGE_COUNT:        avg_count_ff <= csr_chan.data[CNT_W-1:0];
               CSR_REFERENCE_MILLIVOLTS: ref_mv_ff    <= csr_chan.data[VOLT_W-1:0];
               CSR_DIVIDER_RATIO:        ratio_ff     <= csr_chan.data[RATIO_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE && req_fire && accum) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            for (int i = 0; i < NUM_CH; i++) begin
               sums_ff[i] <= sums_ff[i] + samples[i];
            end
         end
         if (state_ff == ST_DONE && slot_free) begin
            rsp_valid_ff <= 1'b1;
            cnt_ff       <= '0;
            for (int i = 0; i < NUM_CH; i++) begin
               sums_ff[i] <= '0;
            end
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            chan_ff <= CH_SUPPLY;
            dvd_ff  <= {sums_ff[CH_SUPPLY], (PROD_W - SUM_W)'(0)};
            rem_ff  <= '0;
            dvs_ff  <= AVG_W'(eff_n);
            step_ff <= STEP_W'(SUM_W);
         end
         ST_AVG: begin
            if (step_ff != '0) begin
               dvd_ff  <= dvd_next;
               rem_ff  <= rem_next;
               step_ff <= step_ff - STEP_W'(1);
            end else begin
               avg_ff[chan_ff] <= quot_avg;
               if (chan_ff != CH_REF) begin
                  chan_ff <= chan_next;
                  dvd_ff  <= {sums_ff[chan_next], (PROD_W - SUM_W)'(0)};
                  rem_ff  <= '0;
                  step_ff <= STEP_W'(SUM_W);
               end
            end
         end
         ST_MUL1: begin
            prod_ff <= MUL_W'(ref_mv_ff * avg_ff[CH_SUPPLY]);
         end
         ST_MUL2: begin
            dvd_ff  <= PROD_W'(prod_ff * ratio_ff);
            rem_ff  <= '0;
            dvs_ff  <= avg_ff[CH_REF];
            step_ff <= STEP_W'(PROD_W);
         end
         ST_VDIV: begin
            if (step_ff != '0) begin
               dvd_ff  <= dvd_next;
               rem_ff  <= rem_next;
               step_ff <= step_ff - STEP_W'(1);
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_data_ff.thermistor1_average <= avg_ff[1];
               rsp_data_ff.thermistor2_average <= avg_ff[2];
               rsp_data_ff.current_average     <= avg_ff[3];
               rsp_data_ff.reference_average   <= avg_ff[CH_REF];
               if (avg_ff[CH_REF] == '0) begin
                  rsp_data_ff.supply_voltage    <= VOLT_MAX;
                  rsp_data_ff.reference_zero    <= 1'b1;
                  rsp_data_ff.voltage_saturated <= 1'b0;
               end else if (dvd_ff > PROD_W'(VOLT_MAX)) begin
                  rsp_data_ff.supply_voltage    <= VOLT_MAX;
                  rsp_data_ff.reference_zero    <= 1'b0;
                  rsp_data_ff.voltage_saturated <= 1'b1;
               end else begin
                  rsp_data_ff.supply_voltage    <= dvd_ff[VOLT_W-1:0];
                  rsp_data_ff.reference_zero    <= 1'b0;
                  rsp_data_ff.voltage_saturated <= 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result appeared without a completed block");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AVG || state_ff == ST_VDIV) |-> dvs_ff != '0)
      else $error("divider running with a zero divisor");

   a_block_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && slot_free) |=> (cnt_ff == '0 && state_ff == ST_IDLE))
      else $error("sample counter not cleared after a block closed");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.reference_zero && rsp_data_ff.voltage_saturated))
      else $error("zero-reference and saturation flags both set");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> rsp_valid_ff)
      else $error("pending result dropped before it was taken");

endmodule

`default_nettype wire

@@ dv/adc_block_average_ratiometric_top_tb.sv @@
// Self-checking testbench for adc_block_average_ratiometric_top.
// Drives sample, result and register channels through the interfaces in adcbar_if.sv
// and predicts every averaged result from types and constants in adcbar_pkg.
module adc_block_average_ratiometric_top_tb;
   import adcbar_pkg::*;

   localparam int MAX_AVERAGE   = 256;
   localparam int SETTLE_CYCLES = 200;
   localparam int LIMIT_CYCLES  = 1000000;
   localparam int SEGMENTS      = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam logic [SAMPLE_W-1:0]  CODE_MAX     = '1;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] value;
   } reg_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   adcbar_req_if req_chan();
   adcbar_rsp_if rsp_chan();
   adcbar_csr_if csr_chan();

   req_type       pending_samples[$];
   reg_write_type pending_writes[$];
   rsp_type       expected_results[$];

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned failures       = 0;
   int unsigned cycle_count    = 0;
   int unsigned samples_taken  = 0;
   int unsigned results_seen   = 0;
   int unsigned zero_ref_seen  = 0;
   int unsigned clamped_seen   = 0;
   int unsigned writes_done    = 0;

   logic [CNT_W-1:0]   model_length;
   logic [VOLT_W-1:0]  model_ref_mv;
   logic [RATIO_W-1:0] model_ratio;
   int unsigned        model_count;
   int unsigned        model_sums[NUM_CH];

   adc_block_average_ratiometric_top #(
      .SAMPLE_BITS(SAMPLE_W),
      .MAX_AVERAGE(MAX_AVERAGE)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Sums one sample of each channel into the running block, or closes the block
   // and queues the averaged result.
   function automatic void absorb_samples(input req_type s);
      int unsigned     length;
      int unsigned     avg[NUM_CH];
      longint unsigned product;
      rsp_type         r;
      length = (model_length == 0) ? 1 : 32'(model_length);
      if (length > MAX_AVERAGE) length = MAX_AVERAGE;
      if (model_count < length) begin
         for (int i = 0; i < NUM_CH; i++)
            model_sums[i] += 32'(s[(NUM_CH - 1 - i) * SAMPLE_W +: SAMPLE_W]);
         model_count++;
      end else begin
         for (int i = 0; i < NUM_CH; i++) begin
            avg[i] = model_sums[i] / length;
            if (avg[i] > AVG_MAX) avg[i] = AVG_MAX;
            model_sums[i] = 0;
         end
         model_count = 0;
         r = '0;
         r.thermistor1_average = AVG_W'(avg[1]);
         r.thermistor2_average = AVG_W'(avg[2]);
         r.current_average     = AVG_W'(avg[3]);
         r.reference_average   = AVG_W'(avg[4]);
         if (avg[CH_REF] == 0) begin
            r.supply_voltage = VOLT_MAX;
            r.reference_zero = 1'b1;
         end else begin
            product = 64'(model_ref_mv);
            product = product * avg[CH_SUPPLY] * model_ratio / avg[CH_REF];
            if (product > VOLT_MAX) begin
               r.supply_voltage    = VOLT_MAX;
               r.voltage_saturated = 1'b1;
            end else begin
               r.supply_voltage = product[VOLT_W-1:0];
            end
         end
         expected_results.push_back(r);
      end
   endfunction

   function automatic void compare_field(input string name, input logic [VOLT_W-1:0] want,
                                         input logic [VOLT_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         model_length = RESET_AVERAGE_COUNT;
         model_ref_mv = RESET_REFERENCE_MV;
         model_ratio  = RESET_DIVIDER_RATIO;
         model_count  = 0;
         for (int i = 0; i < NUM_CH; i++) model_sums[i] = 0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            writes_done++;
            case (csr_chan.index)
               CSR_AVERAGE_COUNT:        model_length = csr_chan.data[CNT_W-1:0];
               CSR_REFERENCE_MILLIVOLTS: model_ref_mv = csr_chan.data[VOLT_W-1:0];
               CSR_DIVIDER_RATIO:        model_ratio  = csr_chan.data[RATIO_W-1:0];
               default: ;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result transaction with none expected: %p", $time, rsp_chan.data);
               failures++;
            end else begin
               want = expected_results.pop_front();
               results_seen++;
               if (want.reference_zero) zero_ref_seen++;
               if (want.voltage_saturated) clamped_seen++;
               compare_field("supply_voltage", want.supply_voltage,
                             rsp_chan.data.supply_voltage);
               compare_field("thermistor1_average", VOLT_W'(want.thermistor1_average),
                             VOLT_W'(rsp_chan.data.thermistor1_average));
               compare_field("thermistor2_average", VOLT_W'(want.thermistor2_average),
                             VOLT_W'(rsp_chan.data.thermistor2_average));
               compare_field("current_average", VOLT_W'(want.current_average),
                             VOLT_W'(rsp_chan.data.current_average));
               compare_field("reference_average", VOLT_W'(want.reference_average),
                             VOLT_W'(rsp_chan.data.reference_average));
               compare_field("reference_zero", VOLT_W'(want.reference_zero),
                             VOLT_W'(rsp_chan.data.reference_zero));
               compare_field("voltage_saturated", VOLT_W'(want.voltage_saturated),
                             VOLT_W'(rsp_chan.data.voltage_saturated));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            samples_taken++;
            absorb_samples(req_chan.data);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_chan.valid <= 1'b1;
            req_chan.data  <= pending_samples[0];
            void'(pending_samples.pop_front());
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset) begin
         csr_chan.valid <= 1'b0;
      end else if (!csr_chan.valid || csr_chan.ready) begin
         if (pending_writes.size() != 0) begin
            csr_chan.valid <= 1'b1;
            csr_chan.index <= pending_writes[0].index;
            csr_chan.data  <= pending_writes[0].value;
            void'(pending_writes.pop_front());
         end else begin
            csr_chan.valid <= 1'b0;
         end
      end
   end

   function automatic req_type random_samples();
      req_type s;
      for (int i = 0; i < NUM_CH; i++) begin
         case ($urandom_range(9))
            0:       s[i * SAMPLE_W +: SAMPLE_W] = '0;
            1:       s[i * SAMPLE_W +: SAMPLE_W] = CODE_MAX;
            2:       s[i * SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(3));
            default: s[i * SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom);
         endcase
      end
      return s;
   endfunction

   task automatic wait_until_idle();
      while (pending_samples.size() != 0 || req_chan.valid || pending_writes.size() != 0 ||
             csr_chan.valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_registers(input logic [CSR_DATA_W-1:0] length,
                                  input logic [CSR_DATA_W-1:0] ref_mv,
                                  input logic [CSR_DATA_W-1:0] ratio);
      wait_until_idle();
      pending_writes.push_back('{CSR_AVERAGE_COUNT, length});
      pending_writes.push_back('{CSR_REFERENCE_MILLIVOLTS, ref_mv});
      pending_writes.push_back('{CSR_DIVIDER_RATIO, ratio});
      wait_until_idle();
   endtask

   initial begin
      int unsigned           count;
      int unsigned           pick;
      logic [CSR_DATA_W-1:0] length, ref_mv, ratio;

      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Full-scale codes with the largest multiplier and divider overflow the voltage.
      write_registers(16'd1, VOLT_MAX, 16'd255);
      pending_samples.push_back('{CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX});
      pending_samples.push_back(random_samples());
      pending_samples.push_back('{CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, 12'd0});
      pending_samples.push_back(random_samples());
      pending_samples.push_back('{12'd0, 12'd0, 12'd0, 12'd0, CODE_MAX});
      pending_samples.push_back(random_samples());

      // A zero divider ratio, then a zero averaging length that must act as one.
      write_registers(16'd1, 16'd2500, 16'd0);
      pending_samples.push_back(random_samples());
      pending_samples.push_back(random_samples());
      write_registers(16'd0, 16'd2500, 16'd1);
      pending_samples.push_back(random_samples());
      pending_samples.push_back(random_samples());

      // A write to an index past the register list must change nothing.
      wait_until_idle();
      pending_writes.push_back('{CSR_UNMAPPED, 16'hFFFF});
      wait_until_idle();
      pending_samples.push_back(random_samples());
      pending_samples.push_back(random_samples());

      // Lowering the length mid-block closes it early with oversized sums.
      write_registers(16'd8, 16'd2500, 16'd1);
      repeat (5) pending_samples.push_back('{CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX});
      write_registers(16'd2, 16'd2500, 16'd1);
      pending_samples.push_back(random_samples());

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         count = 100;
         case (seg)
            0: begin
               length = 16'd256;
               ref_mv = VOLT_MAX;
               ratio  = 16'd255;
               count  = 520;
            end
            1: begin
               length = 16'd1;
               ref_mv = 16'd0;
               ratio  = 16'd255;
            end
            2: begin
               length = 16'hFFFF;
               ref_mv = 16'd2500;
               ratio  = 16'd1;
            end
            3: begin
               length = 16'd1;
               ref_mv = VOLT_MAX;
               ratio  = 16'd1;
            end
            default: begin
               case ($urandom_range(9))
                  0, 1, 2, 3, 4, 5: pick = $urandom_range(1, 4);
                  6, 7:             pick = $urandom_range(5, 20);
                  8:                pick = $urandom_range(21, 64);
                  default:          pick = $urandom_range(1) ? 0 : 300;
               endcase
               length = {7'($urandom), CNT_W'(pick)};
               case ($urandom_range(3))
                  0:       ref_mv = 16'd0;
                  1:       ref_mv = VOLT_MAX;
                  default: ref_mv = 16'($urandom);
               endcase
               pick  = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 255);
               ratio = {8'($urandom), RATIO_W'(pick)};
            end
         endcase
         write_registers(length, ref_mv, ratio);
         case (seg % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 80;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 80;
            end
            default: begin
               send_idle_pct  = 11;
               recv_stall_pct = 11;
            end
         endcase
         repeat (count) pending_samples.push_back(random_samples());
      end

      wait_until_idle();
      $display("summary: %0d sample transactions, %0d averaged results checked",
               samples_taken, results_seen);
      $display("summary: %0d with zero reference, %0d with clamped voltage, %0d register writes",
               zero_ref_seen, clamped_seen, writes_done);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
